// ===== hdl/differential_drive_mixer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Differential drive mixer assertion macros
// Concurrent assertion shorthands; empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_MIXER_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_MIXER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, ignored while reset is asserted.
`define DDM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");
// Next-cycle implication, ignored while reset is asserted.
`define DDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");
`else
`define DDM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DDM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/ddm_pkg.sv =====
// ----------------------------------------------------------------------------
// Differential drive mixer package
// Stick limits, reciprocal constants, direction codes and stage structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ddm_pkg;

    localparam logic [7:0] STICK_MAX = 8'd250;
    localparam logic [7:0] BAND_HI   = 8'd135;
    localparam logic [7:0] BAND_LO   = 8'd115;

    // base = (2 * lim) / 5, exact as (x * 205) >> 10 for x below 1024.
    localparam int         BASE_NUM_W  = 9;
    localparam logic [7:0] BASE_RECIP  = 8'd205;
    localparam int         BASE_SHIFT  = 10;
    localparam int         BASE_FULL_W = BASE_NUM_W + 8;
    localparam int         BASE_W      = 7;

    // p / 115, exact as (p * 36473) >> 22 for p below 46090.
    localparam int          EXC_W       = 8;
    localparam int          PROD_W      = EXC_W + BASE_W;
    localparam logic [15:0] SPAN_RECIP  = 16'd36473;
    localparam int          SPAN_SHIFT  = 22;
    localparam int          QUOT_FULL_W = PROD_W + 16;
    localparam int          SPEED_W     = 8;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    typedef struct packed {
        dir_t             left_dir;
        dir_t             right_dir;
        logic [EXC_W-1:0] left_exc;
        logic [EXC_W-1:0] right_exc;
    } mix_t;

    typedef struct packed {
        mix_t                  mix;
        logic [BASE_NUM_W-1:0] base_num;
    } stage_a_t;

    typedef struct packed {
        mix_t              mix;
        logic [BASE_W-1:0] base;
    } stage_b_t;

    typedef struct packed {
        dir_t              left_dir;
        dir_t              right_dir;
        logic [PROD_W-1:0] left_prod;
        logic [PROD_W-1:0] right_prod;
    } stage_c_t;

    function automatic logic [7:0] clamp_stick(input logic [7:0] v);
        return (v > STICK_MAX) ? STICK_MAX : v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ddm_mix.sv =====
// ----------------------------------------------------------------------------
// Differential drive mixer front end
// Clamps the sticks and works out each wheel's direction and stick excess.
// ----------------------------------------------------------------------------
`default_nettype none

module ddm_mix (
    input  wire logic [7:0]      throttle_axis,
    input  wire logic [7:0]      steer_axis,
    input  wire logic [7:0]      speed_limit_axis,
    output ddm_pkg::stage_a_t    stage_a
);
    import ddm_pkg::*;

    logic [7:0]       thr;
    logic [7:0]       str;
    logic [7:0]       lim;
    logic             fwd;
    logic             back;
    logic             steer_hi;
    logic             steer_lo;
    logic [EXC_W-1:0] tx;
    logic [EXC_W-1:0] sx;
    logic             boost_l;
    logic             boost_r;

    always_comb
    begin
        thr = clamp_stick(throttle_axis);
        str = clamp_stick(steer_axis);
        lim = clamp_stick(speed_limit_axis);

        fwd      = thr > BAND_HI;
        back     = thr < BAND_LO;
        steer_hi = str > BAND_HI;
        steer_lo = str < BAND_LO;

        tx = fwd ? thr - BAND_HI : (back ? BAND_LO - thr : '0);
        sx = steer_hi ? str - BAND_HI : (steer_lo ? BAND_LO - str : '0);

        // Driving forward, high steer speeds up the right wheel; mirrored in reverse.
        boost_l = (fwd && steer_lo) || (back && steer_hi);
        boost_r = (fwd && steer_hi) || (back && steer_lo);

        if (fwd || back)
        begin
            stage_a.mix.left_dir  = fwd ? DIR_FWD : DIR_BACK;
            stage_a.mix.right_dir = fwd ? DIR_FWD : DIR_BACK;
            stage_a.mix.left_exc  = tx + (boost_l ? sx : '0);
            stage_a.mix.right_exc = tx + (boost_r ? sx : '0);
        end
        else
        begin
            // Turning in place: at most one wheel runs, forward.
            stage_a.mix.left_dir  = steer_lo ? DIR_FWD : DIR_STOP;
            stage_a.mix.right_dir = steer_hi ? DIR_FWD : DIR_STOP;
            stage_a.mix.left_exc  = steer_lo ? sx : '0;
            stage_a.mix.right_exc = steer_hi ? sx : '0;
        end

        stage_a.base_num = {lim, 1'b0};
    end

endmodule

`default_nettype wire

// ===== hdl/ddm_div115.sv =====
// ----------------------------------------------------------------------------
// Divide by 115
// Reciprocal multiplication for products of excess and base speed.
// ----------------------------------------------------------------------------
`default_nettype none

module ddm_div115 (
    input  wire logic [ddm_pkg::PROD_W-1:0]  prod,
    output logic      [ddm_pkg::SPEED_W-1:0] quot
);
    import ddm_pkg::*;

    logic [QUOT_FULL_W-1:0] full;

    assign full = QUOT_FULL_W'(prod) * QUOT_FULL_W'(SPAN_RECIP);
    assign quot = full[SPAN_SHIFT +: SPEED_W];

endmodule

`default_nettype wire

// ===== hdl/differential_drive_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// Differential drive mixer unit
// Turns throttle, steering and speed knob samples into wheel drive commands.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                   Payload
//  -------  --------------------------  -------------------------------------
//  item     item_valid / item_ready     throttle_axis, steer_axis,
//                                       speed_limit_axis
//  result   result_valid / result_ready left_direction, right_direction,
//                                       left_speed, right_speed
//
//  The unit accepts one item per clock cycle while no stall holds it back,
//  and each result passes through the four register stages A to D.
//  Reset clears only the stage valid bits, so the pipeline comes up empty.
//  A stall at the result port holds the final stage, and each earlier stage
//  keeps loading while a bubble sits ahead of it, so no item is lost or
//  repeated and empty slots are squeezed out during a stall.
//
`default_nettype none

`include "differential_drive_mixer_unit_macros.svh"

module differential_drive_mixer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic [7:0] throttle_axis,
    input  wire logic [7:0] steer_axis,
    input  wire logic [7:0] speed_limit_axis,

    output logic            result_valid,
    input  wire logic       result_ready,
    output logic [1:0]      left_direction,
    output logic [1:0]      right_direction,
    output logic [7:0]      left_speed,
    output logic [7:0]      right_speed
);
    import ddm_pkg::*;

    // Stage valid bits and the ready chain that runs back from the output.
    logic valid_a_reg;
    logic valid_b_reg;
    logic valid_c_reg;
    logic valid_d_reg;
    logic ready_a;
    logic ready_b;
    logic ready_c;
    logic ready_d;

    stage_a_t stage_a_next;
    stage_a_t stage_a_reg;
    stage_b_t stage_b_next;
    stage_b_t stage_b_reg;
    stage_c_t stage_c_next;
    stage_c_t stage_c_reg;

    logic [BASE_FULL_W-1:0] base_full;
    logic [SPEED_W-1:0]     left_speed_next;
    logic [SPEED_W-1:0]     right_speed_next;
    dir_t                   left_dir_reg;
    dir_t                   right_dir_reg;
    logic [SPEED_W-1:0]     left_speed_reg;
    logic [SPEED_W-1:0]     right_speed_reg;

    // A stage may load when it is empty or when its item moves on this cycle.
    assign ready_d    = !valid_d_reg || result_ready;
    assign ready_c    = !valid_c_reg || ready_d;
    assign ready_b    = !valid_b_reg || ready_c;
    assign ready_a    = !valid_a_reg || ready_b;
    assign item_ready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                valid_a_reg <= item_valid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
            if (ready_c)
            begin
                valid_c_reg <= valid_b_reg;
            end
            if (ready_d)
            begin
                valid_d_reg <= valid_c_reg;
            end
        end
    end

    // Stage A: clamp the sticks and mix them into per-wheel excess values.
    ddm_mix u_mix (
        .throttle_axis    (throttle_axis),
        .steer_axis       (steer_axis),
        .speed_limit_axis (speed_limit_axis),
        .stage_a          (stage_a_next)
    );

    // Stage B: scale the speed knob to a base speed of 0 to 100.
    assign base_full = BASE_FULL_W'(stage_a_reg.base_num) * BASE_FULL_W'(BASE_RECIP);

    always_comb
    begin
        stage_b_next.mix  = stage_a_reg.mix;
        stage_b_next.base = base_full[BASE_SHIFT +: BASE_W];
    end

    // Stage C: multiply each wheel's excess by the base speed.
    always_comb
    begin
        stage_c_next.left_dir   = stage_b_reg.mix.left_dir;
        stage_c_next.right_dir  = stage_b_reg.mix.right_dir;
        stage_c_next.left_prod  = PROD_W'(stage_b_reg.mix.left_exc) * PROD_W'(stage_b_reg.base);
        stage_c_next.right_prod = PROD_W'(stage_b_reg.mix.right_exc) * PROD_W'(stage_b_reg.base);
    end

    // Stage D: divide both products by the excess span of 115.
    ddm_div115 u_div_left (
        .prod (stage_c_reg.left_prod),
        .quot (left_speed_next)
    );

    ddm_div115 u_div_right (
        .prod (stage_c_reg.right_prod),
        .quot (right_speed_next)
    );

    // Payload registers need no reset; they load only with a valid item.
    always_ff @(posedge clk)
    begin
        if (item_valid && ready_a)
        begin
            stage_a_reg <= stage_a_next;
        end
        if (valid_a_reg && ready_b)
        begin
            stage_b_reg <= stage_b_next;
        end
        if (valid_b_reg && ready_c)
        begin
            stage_c_reg <= stage_c_next;
        end
        if (valid_c_reg && ready_d)
        begin
            left_dir_reg    <= stage_c_reg.left_dir;
            right_dir_reg   <= stage_c_reg.right_dir;
            left_speed_reg  <= left_speed_next;
            right_speed_reg <= right_speed_next;
        end
    end

    assign result_valid    = valid_d_reg;
    assign left_direction  = left_dir_reg;
    assign right_direction = right_dir_reg;
    assign left_speed      = left_speed_reg;
    assign right_speed     = right_speed_reg;

    // A stopped wheel always reports zero speed.
    `DDM_ASSERT_IMPLY(a_left_stop_zero, clk, rst_n, result_valid && left_direction == DIR_STOP, left_speed == '0)
    `DDM_ASSERT_IMPLY(a_right_stop_zero, clk, rst_n, result_valid && right_direction == DIR_STOP, right_speed == '0)
    // The wheels never run in opposite directions.
    `DDM_ASSERT_IMPLY(a_no_counter_rotation, clk, rst_n, result_valid && left_direction != right_direction, left_direction == DIR_STOP || right_direction == DIR_STOP)
    // An item held in the last stage by a stall is still there next cycle.
    `DDM_ASSERT_NEXT(a_stall_holds_stage, clk, rst_n, valid_d_reg && !result_ready, valid_d_reg)

endmodule

`default_nettype wire
